[src/c128c_pkg.sv]
package c128c_pkg;

	// One input transaction: a pair of ASCII digits
	typedef struct packed {
		logic [7:0] first_char;
		logic [7:0] second_char;
		logic       last_pair;
	} pair_t;

	// One output transaction: a symbol with its element widths
	typedef struct packed {
		logic [6:0] symbol_value;
		logic [2:0] bar_one;
		logic [2:0] space_one;
		logic [2:0] bar_two;
		logic [2:0] space_two;
		logic [2:0] bar_three;
		logic [2:0] space_three;
		logic [1:0] bar_four;
		logic       guard_symbol;
		logic       bad_digit;
		logic       end_of_run;
	} sym_t;

	// Classified pair, passed from front end to back end
	typedef struct packed {
		logic       bad;    // pair held a non-digit
		logic       start;  // first pair of a message: start C goes first
		logic       last;   // last pair: check and stop follow
		logic [6:0] code;   // data symbol value 0..99
		logic [6:0] rem;    // code * weight mod 103
	} cmd_t;

	localparam logic [6:0] SymStartC  = 7'd105;
	localparam logic [6:0] SymStop    = 7'd106;
	localparam logic [6:0] CheckMod   = 7'd103;
	localparam logic [6:0] StartCheck = 7'd2;    // 105 mod 103
	localparam logic [6:0] WeightWrap = 7'd102;

	// floor(x / 103) == (x * 10181) >> 20 for every x below 10200
	localparam logic [13:0] RecipMul   = 14'd10181;
	localparam int          RecipShift = 20;

	localparam logic [23:0] StopPattern = 24'h233111;

	// Element widths, one nibble each, first bar in the top nibble
	localparam logic [23:0] WidthTab [0:105] = '{
		24'h212222, 24'h222122, 24'h222221, 24'h121223, 24'h121322,
		24'h131222, 24'h122213, 24'h122312, 24'h132212, 24'h221213,
		24'h221312, 24'h231212, 24'h112232, 24'h122132, 24'h122231,
		24'h113222, 24'h123122, 24'h123221, 24'h223211, 24'h221132,
		24'h221231, 24'h213212, 24'h223112, 24'h312131, 24'h311222,
		24'h321122, 24'h321221, 24'h312212, 24'h322112, 24'h322211,
		24'h212123, 24'h212321, 24'h232121, 24'h111323, 24'h131123,
		24'h131321, 24'h112313, 24'h132113, 24'h132311, 24'h211313,
		24'h231113, 24'h231311, 24'h112133, 24'h112331, 24'h132131,
		24'h113123, 24'h113321, 24'h133121, 24'h313121, 24'h211331,
		24'h231131, 24'h213113, 24'h213311, 24'h213131, 24'h311123,
		24'h311321, 24'h331121, 24'h312113, 24'h312311, 24'h332111,
		24'h314111, 24'h221411, 24'h431111, 24'h111224, 24'h111422,
		24'h121124, 24'h121421, 24'h141122, 24'h141221, 24'h112214,
		24'h112412, 24'h122114, 24'h122411, 24'h142112, 24'h142211,
		24'h241211, 24'h221114, 24'h413111, 24'h241112, 24'h134111,
		24'h111242, 24'h121142, 24'h121241, 24'h114212, 24'h124112,
		24'h124211, 24'h411212, 24'h421112, 24'h421211, 24'h212141,
		24'h214121, 24'h412121, 24'h111143, 24'h111341, 24'h131141,
		24'h114113, 24'h114311, 24'h411113, 24'h411311, 24'h113141,
		24'h114131, 24'h311141, 24'h411131, 24'h211412, 24'h211214,
		24'h211232
	};

	function automatic logic [23:0] pattern_of(input logic [6:0] value);
		if (value >= SymStop) begin
			return StopPattern;
		end
		return WidthTab[value];
	endfunction

endpackage

[src/c128c_front.sv]
module c128c_front
	import c128c_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  pair_t pair,
	output logic  cmd_push,
	input  logic  cmd_full,
	output cmd_t  cmd
);

	logic       in_msg_q;
	logic [6:0] weight_q;

	logic       v_s1, v_s2, v_s3, v_s4;
	cmd_t       cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [6:0] w_s1;
	logic [13:0] prod_s2;
	logic [6:0] prod_lo_s3;
	logic [6:0] quo_s3;

	logic       advance;
	logic       accept;
	logic       bad_d;
	logic [3:0] tens_d, units_d;
	logic [6:0] code_d;
	logic [6:0] w_d;
	logic [27:0] scaled;

	// Whole pipeline moves together; it holds only when stage 4 cannot enter the queue
	assign advance  = !v_s4 || !cmd_full;
	assign full     = !advance;
	assign accept   = push && advance;
	assign cmd_push = v_s4 && !cmd_full;
	assign cmd      = cmd_s4;

	// Classify the pair and form its data value
	always_comb begin
		bad_d = !(pair.first_char inside {[8'h30:8'h39]}) ||
			!(pair.second_char inside {[8'h30:8'h39]});
		tens_d  = pair.first_char[3:0];
		units_d = pair.second_char[3:0];
		code_d  = {tens_d, 3'b000} + {2'b00, tens_d, 1'b0} + {3'b000, units_d};
		w_d     = in_msg_q ? weight_q : 7'd1;
	end

	// Message state and pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			weight_q <= 7'd1;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			if (accept) begin
				if (bad_d) begin
					in_msg_q <= 1'b0;
					weight_q <= 7'd1;
				end else begin
					in_msg_q <= !pair.last_pair;
					weight_q <= (w_d == WeightWrap) ? 7'd0 : w_d + 7'd1;
				end
			end
			if (advance) begin
				v_s1 <= accept;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	// Weighted term mod 103: multiply, divide by reciprocal, take remainder
	assign scaled = 28'(prod_s2) * 28'(RecipMul);

	always_ff @(posedge clk) begin
		if (advance) begin
			cmd_s1.bad   <= bad_d;
			cmd_s1.start <= !in_msg_q;
			cmd_s1.last  <= pair.last_pair;
			cmd_s1.code  <= code_d;
			cmd_s1.rem   <= 7'd0;
			w_s1         <= w_d;

			cmd_s2  <= cmd_s1;
			prod_s2 <= 14'(cmd_s1.code) * 14'(w_s1);

			cmd_s3     <= cmd_s2;
			prod_lo_s3 <= prod_s2[6:0];
			quo_s3     <= scaled[RecipShift +: 7];

			cmd_s4 <= '{
				bad:   cmd_s3.bad,
				start: cmd_s3.start,
				last:  cmd_s3.last,
				code:  cmd_s3.code,
				rem:   prod_lo_s3 - 7'(14'(quo_s3) * 14'(CheckMod))
			};
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !advance |=> v_s4 && $stable(cmd_s4))
		else $error("front stage 4 lost its transaction while stalled");

endmodule

[src/c128c_fifo.sv]
module c128c_fifo
	import c128c_pkg::*;
#(
	parameter int Depth = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wr_data,
	output logic full,
	input  logic pop,
	output cmd_t rd_data,
	output logic empty
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);

	cmd_t          mem [Depth];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(Depth));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full || pop) and (pop |-> !empty))
		else $error("command queue overrun or underrun");

endmodule

[src/c128c_back.sv]
module c128c_back
	import c128c_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	output sym_t symbol,
	output logic empty,
	input  logic pop
);

	typedef enum logic [1:0] {PH_START, PH_DATA, PH_CHECK, PH_STOP} phase_t;

	phase_t     phase_q;
	logic       mid_q;     // head command has already emitted a symbol
	logic [6:0] cs_q;      // running checksum mod 103
	logic       out_v_q;
	sym_t       out_q;

	phase_t     cur_phase, next_phase;
	logic       can_load, emit, done;
	logic [6:0] value;
	logic       is_end;
	logic [7:0] sum;
	logic [6:0] cs_next;
	logic [23:0] pat;
	sym_t       res;

	assign can_load = !out_v_q || pop;
	assign emit     = !cmd_empty && can_load;
	assign cmd_pop  = emit && done;
	assign symbol   = out_q;
	assign empty    = !out_v_q;

	// Pick the symbol that the head command produces next
	always_comb begin
		cur_phase  = mid_q ? phase_q : (cmd.start ? PH_START : PH_DATA);
		next_phase = PH_DATA;
		value      = cmd.code;
		done       = 1'b0;
		is_end     = 1'b0;
		case (cur_phase)
			PH_START: begin
				value      = SymStartC;
				next_phase = PH_DATA;
			end
			PH_DATA: begin
				value      = cmd.code;
				next_phase = PH_CHECK;
				done       = !cmd.last;
				is_end     = !cmd.last;
			end
			PH_CHECK: begin
				value      = cs_q;
				next_phase = PH_STOP;
			end
			PH_STOP: begin
				value  = SymStop;
				done   = 1'b1;
				is_end = 1'b1;
			end
			default: begin
				value = cmd.code;
			end
		endcase
		if (cmd.bad) begin
			done   = 1'b1;
			is_end = 1'b1;
		end
	end

	// Checksum accumulate: start C seeds it, each data symbol adds its term
	always_comb begin
		sum     = {1'b0, cmd.start ? StartCheck : cs_q} + {1'b0, cmd.rem};
		cs_next = (sum >= {1'b0, CheckMod}) ? 7'(sum - {1'b0, CheckMod}) : sum[6:0];
	end

	// Result fields from the width table
	always_comb begin
		pat                = pattern_of(value);
		res.symbol_value   = value;
		res.bar_one        = pat[22:20];
		res.space_one      = pat[18:16];
		res.bar_two        = pat[14:12];
		res.space_two      = pat[10:8];
		res.bar_three      = pat[6:4];
		res.space_three    = pat[2:0];
		res.bar_four       = (value == SymStop) ? 2'd2 : 2'd0;
		res.guard_symbol   = (value == SymStartC) || (value == SymStop);
		res.bad_digit      = 1'b0;
		res.end_of_run     = is_end;
		if (cmd.bad) begin
			res            = '0;
			res.bad_digit  = 1'b1;
			res.end_of_run = 1'b1;
		end
	end

	// Sequencer state, checksum and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			mid_q   <= 1'b0;
			cs_q    <= 7'd0;
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else begin
			if (emit) begin
				out_v_q <= 1'b1;
				out_q   <= res;
				mid_q   <= !done;
				phase_q <= next_phase;
				if (!cmd.bad && cur_phase == PH_DATA) begin
					cs_q <= cs_next;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	a_cs_range: assert property (@(posedge clk) disable iff (!arst_n)
		cs_q < CheckMod)
		else $error("checksum out of range");

	a_err_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.bad_digit |-> out_q.end_of_run && out_q.symbol_value == 7'd0)
		else $error("error transaction not closing its run");

endmodule

[src/code128c_symbol_encoder.sv]
// Channel  | Handshake        | Payload          | Moves
// ---------+------------------+------------------+----------------------------------
// input    | push / full      | pair   (pair_t)  | one ASCII digit pair per transaction
// output   | empty / pop      | symbol (sym_t)   | one Code 128 symbol per transaction
//
// Flow: one pair accepted per cycle while full is low; a message of N pairs gives
//   N+3 results (start, check, stop), an error a single result.
// Path: the first result of a pair reaches the ports through four front stages for
//   the mod-103 term, the command queue and the output register.
// Reset: arst_n clears all control state; the next pair opens a new message.
// Stalls: full rises only when the last front stage cannot enter a full command
//   queue; a popped output register is reloaded in that cycle if a command waits.
module code128c_symbol_encoder
	import c128c_pkg::*;
#(
	parameter int QueueDepth = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  pair_t pair,
	output logic  empty,
	input  logic  pop,
	output sym_t  symbol
);

	logic cmd_push, cmd_full, cmd_pop, cmd_empty;
	cmd_t cmd_in, cmd_out;

	c128c_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.pair     (pair),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full),
		.cmd      (cmd_in)
	);

	c128c_fifo #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full),
		.pop     (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	c128c_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.symbol    (symbol),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
